>>> sv/deq_pkg.sv
// Shared types and defaults for the double-ended queue core.
`default_nettype none

package deq_pkg;

   // Default ring size and element width.
   localparam int unsigned CAPACITY_DEFAULT   = 16;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   // Operation codes carried on the request side.
   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   // Status codes returned with every response.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> sv/deq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module deq_ram #(
   parameter int unsigned WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int unsigned DEPTH = deq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Reads return the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> sv/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
//
// Usage: each request item carries an operation code on req_tuser (push front,
// push back, pop front, pop back) and a value on req_tdata that only pushes use.
// Every request item produces exactly one response item on the rsp_ channel with
// the popped value, the front and back values after the operation, the element
// count and a status code (ok, pop on empty refused, push on full refused).
// The core takes one item per cycle unless stalled. A response appears in the
// cycle after its request is accepted and sits in the output register until
// it is taken. The rate is set by the single output register: a request is
// accepted when that register is empty or is being emptied in the same cycle,
// so a stalled receiver stalls the request side too; nothing is lost or repeated.
// The front and back elements are held in registers; the elements one step
// further in are prefetched from a two-read-port ring RAM every cycle, with
// the write of the previous cycle forwarded, so a pop finds its successor
// without waiting. Reset (synchronous, active high) empties the queue and
// drops any pending response; the RAM itself is not cleared, since no entry
// is ever read before it is written.
`default_nettype none

module double_ended_queue_core #(
   parameter int unsigned CAPACITY   = deq_pkg::CAPACITY_DEFAULT,
   parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] push_value
   input  wire logic [1:0]   req_tuser,   // [1:0] operation
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
   // [100:96] element_count, [103:101] zero
   output logic      [103:0] rsp_tdata,
   output logic      [1:0]   rsp_tuser    // [1:0] status
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   // Ring index step forward and backward with wrap.
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
   endfunction

   // Queue state: head points at the front element, tail at the back element.
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;

   // Last RAM write and the read addresses issued at the same edge.
   logic                  wr_pend_ff;
   logic [IDX_W-1:0]      wr_addr_ff;
   logic [DATA_WIDTH-1:0] wr_data_ff;
   logic [IDX_W-1:0]      rd_front_addr_ff;
   logic [IDX_W-1:0]      rd_back_addr_ff;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [103:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  accept;
   logic                  is_full;
   logic                  is_empty;
   deq_pkg::op_type       op;
   logic [DATA_WIDTH+31:0] value_ext;
   logic [DATA_WIDTH-1:0] value;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_front_addr;
   logic [IDX_W-1:0]      rd_back_addr;
   logic [DATA_WIDTH-1:0] ram_rd_front;
   logic [DATA_WIDTH-1:0] ram_rd_back;
   logic [DATA_WIDTH-1:0] front2;
   logic [DATA_WIDTH-1:0] back2;
   logic [DATA_WIDTH-1:0] popped;
   deq_pkg::status_type   status;
   logic [DATA_WIDTH+31:0] popped_ext;
   logic [DATA_WIDTH+31:0] front_ext;
   logic [DATA_WIDTH+31:0] back_ext;
   logic [CNT_W+4:0]      count_ext;

   // A request enters when the response register is free or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == FULL_CNT);
   assign is_empty   = (count_ff == '0);
   assign op         = deq_pkg::op_type'(req_tuser);

   // The push value keeps its low DATA_WIDTH bits, zero-extended if wider.
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_tdata};
   assign value      = value_ext[DATA_WIDTH-1:0];

   // Second-from-front and second-from-back, with the last write forwarded
   // because the RAM returns old data on a same-edge collision.
   assign front2 = (wr_pend_ff && (wr_addr_ff == rd_front_addr_ff)) ? wr_data_ff
                                                                     : ram_rd_front;
   assign back2  = (wr_pend_ff && (wr_addr_ff == rd_back_addr_ff)) ? wr_data_ff
                                                                    : ram_rd_back;

   // Operation decode and next queue state.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      front_in = front_ff;
      back_in  = back_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_dec(head_ff);
      popped   = '0;
      status   = deq_pkg::ST_OK;
      if (accept) begin
         unique case (op)
            deq_pkg::OP_PUSH_FRONT: begin
               if (is_full) begin
                  status = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_dec(head_ff);
                  head_in  = idx_dec(head_ff);
                  count_in = count_ff + ONE_CNT;
                  front_in = value;
                  if (is_empty) begin
                     back_in = value;
                  end
               end
            end
            deq_pkg::OP_PUSH_BACK: begin
               if (is_full) begin
                  status = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_inc(tail_ff);
                  tail_in  = idx_inc(tail_ff);
                  count_in = count_ff + ONE_CNT;
                  back_in  = value;
                  if (is_empty) begin
                     front_in = value;
                  end
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               if (is_empty) begin
                  status = deq_pkg::ST_EMPTY;
               end else begin
                  popped   = front_ff;
                  head_in  = idx_inc(head_ff);
                  count_in = count_ff - ONE_CNT;
                  if (count_ff == ONE_CNT) begin
                     front_in = '0;
                     back_in  = '0;
                  end else begin
                     front_in = front2;
                  end
               end
            end
            deq_pkg::OP_POP_BACK: begin
               if (is_empty) begin
                  status = deq_pkg::ST_EMPTY;
               end else begin
                  popped   = back_ff;
                  tail_in  = idx_dec(tail_ff);
                  count_in = count_ff - ONE_CNT;
                  if (count_ff == ONE_CNT) begin
                     front_in = '0;
                     back_in  = '0;
                  end else begin
                     back_in = back2;
                  end
               end
            end
            default: begin
               status = deq_pkg::ST_OK;
            end
         endcase
      end
   end

   // Prefetch the neighbors of the next front and back every cycle.
   assign rd_front_addr = idx_inc(head_in);
   assign rd_back_addr  = idx_dec(tail_in);

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value),
      .rd_addr_a (rd_front_addr),
      .rd_addr_b (rd_back_addr),
      .rd_data_a (ram_rd_front),
      .rd_data_b (ram_rd_back)
   );

   // Response packing; values are shown in 32 bits.
   assign popped_ext = {32'b0, popped};
   assign front_ext  = {32'b0, front_in};
   assign back_ext   = {32'b0, back_in};
   assign count_ext  = {5'b0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b0, count_ext[4:0], back_ext[31:0], front_ext[31:0],
                         popped_ext[31:0]};
         rsp_user_in  = status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= LAST_IDX;
         count_ff     <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         wr_pend_ff   <= wr_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff       <= wr_addr;
      wr_data_ff       <= value;
      rd_front_addr_ff <= rd_front_addr;
      rd_back_addr_ff  <= rd_back_addr;
      rsp_data_ff      <= rsp_data_in;
      rsp_user_ff      <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The count never runs past the ring size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("element count exceeds capacity");

   // An empty queue shows zero at both ends.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> ((front_ff == '0) && (back_ff == '0)))
      else $error("empty queue holds nonzero end values");

   // With one element the head and tail pointers meet.
   a_single_ptr: assert property (@(posedge clock) disable iff (reset)
      (count_ff == ONE_CNT) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with one element");

   // A refused push leaves the count unchanged.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && is_full && ((op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_BACK)))
      |=> (count_ff == $past(count_ff)))
      else $error("refused push changed the count");

   // A refused pop leaves the queue empty.
   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && is_empty && ((op == deq_pkg::OP_POP_FRONT) || (op == deq_pkg::OP_POP_BACK)))
      |=> (count_ff == '0))
      else $error("refused pop changed the count");

endmodule

`default_nettype wire
